// File: rtl/core/rtc_date_to_epoch_seconds_unit_assert.svh
// assertion macros for the rtc date to epoch seconds unit
// used by the checker file; needs no other file
`ifndef RTC_DATE_TO_EPOCH_SECONDS_UNIT_ASSERT_SVH
`define RTC_DATE_TO_EPOCH_SECONDS_UNIT_ASSERT_SVH

// same-cycle implication
`define RDTE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rdte assertion failed");

// next-cycle implication
`define RDTE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rdte assertion failed");

`endif

// File: rtl/core/rdte_pkg.sv
// shared widths, constants, types and decode functions of the rtc date unit
// no dependencies
package rdte_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned YEAR_W  = 15;
   localparam int unsigned QUOT_W  = 9;
   localparam int unsigned DAYS_W  = 24;
   localparam int unsigned TOD_W   = 20;
   localparam int unsigned EPOCH_W = 40;

   localparam logic [YEAR_W-1:0] EPOCH_YEAR     = 15'd1970;
   localparam logic [YEAR_W-1:0] DEFAULT_CENT   = 15'd2000;
   localparam logic [DAYS_W-1:0] LEAPS_TO_1969  = 24'd477;
   // y / 100 == (y * 5243) >> 19 for every y below 2**15
   localparam logic [12:0]       RECIP_100      = 13'd5243;
   localparam int unsigned       RECIP_SHIFT    = 19;

   // status b bits
   localparam int unsigned STB_BINARY = 2;
   localparam int unsigned STB_24H    = 1;

   typedef struct packed {
      logic [BYTE_W-1:0] second;
      logic [BYTE_W-1:0] minute;
      logic [BYTE_W-1:0] hour;
      logic [BYTE_W-1:0] day;
      logic [BYTE_W-1:0] month;
      logic [YEAR_W-1:0] full_year;
   } time_type;

   function automatic logic [BYTE_W-1:0] bcd_byte_decode(input logic [BYTE_W-1:0] v);
      logic [BYTE_W-1:0] hi;
      hi = {4'd0, v[7:4]};
      return 8'(hi * 8'd10) + {4'd0, v[3:0]};
   endfunction

   // x mod 24 for x up to 139, reciprocal multiply
   function automatic logic [BYTE_W-1:0] mod24(input logic [BYTE_W-1:0] x);
      logic [15:0]       p;
      logic [BYTE_W-1:0] q;
      p = {8'd0, x} * 16'd171;
      q = {4'd0, p[15:12]};
      return x - 8'(q * 8'd24);
   endfunction

   // days before the first of the month, months 1..12
   function automatic logic [8:0] month_offset(input logic [BYTE_W-1:0] mon);
      logic [8:0] r;
      case (mon)
         8'd2:    r = 9'd31;
         8'd3:    r = 9'd59;
         8'd4:    r = 9'd90;
         8'd5:    r = 9'd120;
         8'd6:    r = 9'd151;
         8'd7:    r = 9'd181;
         8'd8:    r = 9'd212;
         8'd9:    r = 9'd243;
         8'd10:   r = 9'd273;
         8'd11:   r = 9'd304;
         8'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/core/rtc_date_to_epoch_seconds_unit.sv
// a req transaction reaches rsp_valid through the four pipeline registers; the day-count
// multiply by 86400 is the last stage; one transaction per cycle unless rsp_stall is high
// reset: synchronous, active high; clears all stage valid bits and century_present
// csr_ready is always high; the csr register is read when a transaction enters stage 1
// depends on rdte_pkg
module rtc_date_to_epoch_seconds_unit (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [rdte_pkg::BYTE_W-1:0]    req_raw_seconds,
   input  logic [rdte_pkg::BYTE_W-1:0]    req_raw_minutes,
   input  logic [rdte_pkg::BYTE_W-1:0]    req_raw_hours,
   input  logic [rdte_pkg::BYTE_W-1:0]    req_raw_day,
   input  logic [rdte_pkg::BYTE_W-1:0]    req_raw_month,
   input  logic [rdte_pkg::BYTE_W-1:0]    req_raw_year,
   input  logic [rdte_pkg::BYTE_W-1:0]    req_raw_century,
   input  logic [rdte_pkg::BYTE_W-1:0]    req_status_b,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rdte_pkg::BYTE_W-1:0]    rsp_second,
   output logic [rdte_pkg::BYTE_W-1:0]    rsp_minute,
   output logic [rdte_pkg::BYTE_W-1:0]    rsp_hour,
   output logic [rdte_pkg::BYTE_W-1:0]    rsp_day,
   output logic [rdte_pkg::BYTE_W-1:0]    rsp_month,
   output logic [rdte_pkg::YEAR_W-1:0]    rsp_full_year,
   output logic [rdte_pkg::EPOCH_W-1:0]   rsp_epoch_seconds,
   // configuration write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic                           csr_data
);

   // ---------------------------------------------------------------
   // configuration register
   // ---------------------------------------------------------------
   logic century_present_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         century_present_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         century_present_ff <= csr_data;
      end
   end

   // ---------------------------------------------------------------
   // pipeline flow control: a stage advances when it is empty or
   // the stage after it advances
   // ---------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_adv, s2_adv, s3_adv, s4_adv;

   assign s4_adv    = !s4_valid_ff || !rsp_stall;
   assign s3_adv    = !s3_valid_ff || s4_adv;
   assign s2_adv    = !s2_valid_ff || s3_adv;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   assign req_stall = !s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) s1_valid_ff <= req_valid;
         if (s2_adv) s2_valid_ff <= s1_valid_ff;
         if (s3_adv) s3_valid_ff <= s2_valid_ff;
         if (s4_adv) s4_valid_ff <= s3_valid_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 1: bcd decode unless in binary mode, 12-hour fix-up, century addition
   // ---------------------------------------------------------------
   rdte_pkg::time_type            s1_in, s1_ff;
   logic [rdte_pkg::BYTE_W-1:0]   hr_dec;
   logic [rdte_pkg::BYTE_W-1:0]   cent_dec;
   logic [rdte_pkg::BYTE_W-1:0]   yr_dec;
   logic                          bin_mode;

   always_comb begin
      bin_mode = req_status_b[rdte_pkg::STB_BINARY];
      if (bin_mode) begin
         s1_in.second = req_raw_seconds;
         s1_in.minute = req_raw_minutes;
         s1_in.day    = req_raw_day;
         s1_in.month  = req_raw_month;
         yr_dec       = req_raw_year;
         cent_dec     = req_raw_century;
         hr_dec       = req_raw_hours;
      end else begin
         s1_in.second = rdte_pkg::bcd_byte_decode(req_raw_seconds);
         s1_in.minute = rdte_pkg::bcd_byte_decode(req_raw_minutes);
         s1_in.day    = rdte_pkg::bcd_byte_decode(req_raw_day);
         s1_in.month  = rdte_pkg::bcd_byte_decode(req_raw_month);
         yr_dec       = rdte_pkg::bcd_byte_decode(req_raw_year);
         cent_dec     = rdte_pkg::bcd_byte_decode(req_raw_century);
         // hour decodes bits 6..0 only, pm flag rides along in bit 7
         hr_dec = ({4'd0, req_raw_hours[3:0]} + 8'({5'd0, req_raw_hours[6:4]} * 8'd10))
                  | {req_raw_hours[7], 7'd0};
      end
      // 12-hour mode with pm flag set
      if (!req_status_b[rdte_pkg::STB_24H] && hr_dec[7]) begin
         s1_in.hour = rdte_pkg::mod24({1'b0, hr_dec[6:0]} + 8'd12);
      end else begin
         s1_in.hour = hr_dec;
      end
      if (century_present_ff) begin
         s1_in.full_year = 15'({7'd0, cent_dec} * 15'd100) + {7'd0, yr_dec};
      end else begin
         s1_in.full_year = rdte_pkg::DEFAULT_CENT + {7'd0, yr_dec};
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) s1_ff <= s1_in;
   end

   // ---------------------------------------------------------------
   // stage 2: year / 100 by reciprocal multiply
   // ---------------------------------------------------------------
   rdte_pkg::time_type            s2_ff;
   logic [rdte_pkg::QUOT_W-1:0]   q100_in, q100_ff;
   logic [27:0]                   recip_prod;

   assign recip_prod = {13'd0, s1_ff.full_year} * {15'd0, rdte_pkg::RECIP_100};
   assign q100_in    = recip_prod[rdte_pkg::RECIP_SHIFT +: rdte_pkg::QUOT_W];

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         s2_ff   <= s1_ff;
         q100_ff <= q100_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 3: day count and time of day
   // ---------------------------------------------------------------
   rdte_pkg::time_type            s3_ff;
   logic [rdte_pkg::DAYS_W-1:0]   days_in, days_ff;
   logic [rdte_pkg::TOD_W-1:0]    tod_in, tod_ff;
   logic [rdte_pkg::YEAR_W-1:0]   yr, last_yr, span, q_x100, leaps_last;
   logic [rdte_pkg::QUOT_W-1:0]   q_last;
   logic                          yr_is_cent, is_leap, after_epoch, mon_ok;
   logic [rdte_pkg::DAYS_W-1:0]   year_days, mon_days, day_days;

   always_comb begin
      yr          = s2_ff.full_year;
      q_x100      = 15'({6'd0, q100_ff} * 15'd100);
      yr_is_cent  = (q_x100 == yr);
      is_leap     = (yr[1:0] == 2'd0) && (!yr_is_cent || (q100_ff[1:0] == 2'd0));
      after_epoch = (yr > rdte_pkg::EPOCH_YEAR);
      // leap count up to the year before this one
      last_yr     = yr - 15'd1;
      q_last      = q100_ff - {8'd0, yr_is_cent};
      leaps_last  = {2'd0, last_yr[14:2]} - {6'd0, q_last} + {8'd0, q_last[8:2]};
      span        = yr - rdte_pkg::EPOCH_YEAR;
      year_days   = 24'({9'd0, span} * 24'd365) + {9'd0, leaps_last}
                    - rdte_pkg::LEAPS_TO_1969;
      // months outside 1..12 add nothing
      mon_ok      = (s2_ff.month >= 8'd1) && (s2_ff.month <= 8'd12);
      mon_days    = {15'd0, rdte_pkg::month_offset(s2_ff.month)}
                    + {23'd0, mon_ok && (s2_ff.month >= 8'd3) && is_leap};
      // day zero counts as the first
      day_days    = (s2_ff.day != 8'd0) ? {16'd0, s2_ff.day - 8'd1} : '0;
      days_in     = (after_epoch ? year_days : '0) + mon_days + day_days;
      tod_in      = 20'({12'd0, s2_ff.hour} * 20'd3600)
                    + 20'({12'd0, s2_ff.minute} * 20'd60)
                    + {12'd0, s2_ff.second};
   end

   always_ff @(posedge clock) begin
      if (s3_adv) begin
         s3_ff   <= s2_ff;
         days_ff <= days_in;
         tod_ff  <= tod_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 4: seconds, doubles as the response register
   // ---------------------------------------------------------------
   rdte_pkg::time_type             s4_ff;
   logic [rdte_pkg::EPOCH_W-1:0]   epoch_in, epoch_ff;
   logic [rdte_pkg::EPOCH_W-1:0]   day_secs;

   assign day_secs = {16'd0, days_ff} * 40'd86400;
   assign epoch_in = day_secs + {20'd0, tod_ff};

   always_ff @(posedge clock) begin
      if (s4_adv) begin
         s4_ff    <= s3_ff;
         epoch_ff <= epoch_in;
      end
   end

   assign rsp_valid         = s4_valid_ff;
   assign rsp_second        = s4_ff.second;
   assign rsp_minute        = s4_ff.minute;
   assign rsp_hour          = s4_ff.hour;
   assign rsp_day           = s4_ff.day;
   assign rsp_month         = s4_ff.month;
   assign rsp_full_year     = s4_ff.full_year;
   assign rsp_epoch_seconds = epoch_ff;

endmodule

// File: rtl/core/rdte_checker.sv
// port-level checker for rtc_date_to_epoch_seconds_unit, attached by bind
// depends on rdte_pkg and rtc_date_to_epoch_seconds_unit_assert.svh
`include "rtc_date_to_epoch_seconds_unit_assert.svh"

module rdte_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [rdte_pkg::YEAR_W-1:0]   rsp_full_year,
   input logic [rdte_pkg::EPOCH_W-1:0]  rsp_epoch_seconds
);

   // a stalled response stays
   `RDTE_ASSERT_NEXT(rsp_hold_a, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   // a stalled response keeps its payload
   `RDTE_ASSERT_NEXT(rsp_stable_a, clock, reset, rsp_valid && rsp_stall, $stable(rsp_epoch_seconds) && $stable(rsp_full_year))
   // reset empties the pipeline
   `RDTE_ASSERT_NEXT(rsp_reset_a, clock, 1'b0, reset, !rsp_valid)
   // with no response waiting every stage can move, so requests flow
   `RDTE_ASSERT_IMPL(req_free_a, clock, reset, !rsp_valid, !req_stall)

endmodule

bind rtc_date_to_epoch_seconds_unit rdte_checker u_rdte_checker (.*);

// File: verif/rtc_date_to_epoch_seconds_unit_tb.sv
// self-checking testbench for rtc_date_to_epoch_seconds_unit: rtc snapshots in, decoded date
// and epoch seconds out, compared against an in-bench calendar predictor
// depends on rdte_pkg and the rtc_date_to_epoch_seconds_unit rtl
`timescale 1ns / 1ps

module rtc_date_to_epoch_seconds_unit_tb;

   localparam int unsigned BYTE_W     = rdte_pkg::BYTE_W;
   localparam int unsigned YEAR_W     = rdte_pkg::YEAR_W;
   localparam int unsigned EPOCH_W    = rdte_pkg::EPOCH_W;
   localparam int unsigned STB_BINARY = rdte_pkg::STB_BINARY;
   localparam int unsigned STB_24H    = rdte_pkg::STB_24H;

   localparam int unsigned CLK_HALF     = 5;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 12;   // longer than the pipe is deep
   localparam int unsigned PHASE_ITEMS  = 160;
   localparam int unsigned REPORT_MAX   = 10;

   // days before the first of each month, non-leap year
   localparam int unsigned MONTH_START [12] =
      '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

   // raw register snapshot, one request transaction
   typedef struct packed {
      logic [BYTE_W-1:0] seconds;
      logic [BYTE_W-1:0] minutes;
      logic [BYTE_W-1:0] hours;
      logic [BYTE_W-1:0] day;
      logic [BYTE_W-1:0] month;
      logic [BYTE_W-1:0] year;
      logic [BYTE_W-1:0] century;
      logic [BYTE_W-1:0] status_b;
   } snapshot_type;

   // decoded calendar fields plus epoch seconds, one response transaction
   typedef struct packed {
      rdte_pkg::time_type stamp;
      logic [EPOCH_W-1:0] epoch;
   } decoded_type;

   // predicts the decoded date of each accepted snapshot and checks responses in order
   class epoch_scoreboard;
      bit          century_en;
      decoded_type expected_dates[$];
      int unsigned mismatches;

      function int unsigned bcd_value(int unsigned v);
         return ((v >> 4) & 32'hF) * 10 + (v & 32'hF);
      endfunction

      function int unsigned leap_count(int unsigned y);
         return y / 4 - y / 100 + y / 400;
      endfunction

      function decoded_type decode_snapshot(snapshot_type s);
         int unsigned     sec, mins, hr, dom, mon, yr, cent, year, last;
         longint unsigned days, secs;
         decoded_type     d;
         sec  = s.seconds;
         mins = s.minutes;
         hr   = s.hours;
         dom  = s.day;
         mon  = s.month;
         yr   = s.year;
         cent = s.century;
         if (!s.status_b[STB_BINARY]) begin
            sec  = bcd_value(sec);
            mins = bcd_value(mins);
            dom  = bcd_value(dom);
            mon  = bcd_value(mon);
            yr   = bcd_value(yr);
            cent = bcd_value(cent);
            // pm flag survives the bcd decode of the hour
            hr = ((hr & 32'h0F) + ((hr >> 4) & 32'h7) * 10) | (hr & 32'h80);
         end
         if (!s.status_b[STB_24H] && (hr & 32'h80) != 0)
            hr = ((hr & 32'h7F) + 12) % 24;
         year = century_en ? cent * 100 + yr : 2000 + yr;
         days = 0;
         if (year > 1970) begin
            last = year - 1;
            days = 365 * (last - 1969) + leap_count(last) - leap_count(1969);
         end
         if (mon >= 1 && mon <= 12) begin
            days += MONTH_START[mon - 1];
            if (mon >= 3 && year % 4 == 0 && (year % 100 != 0 || year % 400 == 0))
               days += 1;
         end
         if (dom > 0)
            days += dom - 1;
         secs = days * 86400 + longint'(hr) * 3600 + longint'(mins) * 60 + sec;
         d.stamp.second    = BYTE_W'(sec);
         d.stamp.minute    = BYTE_W'(mins);
         d.stamp.hour      = BYTE_W'(hr);
         d.stamp.day       = BYTE_W'(dom);
         d.stamp.month     = BYTE_W'(mon);
         d.stamp.full_year = YEAR_W'(year);
         d.epoch           = EPOCH_W'(secs);
         return d;
      endfunction

      function void note_snapshot(snapshot_type s);
         expected_dates.push_back(decode_snapshot(s));
      endfunction

      function void check_result(decoded_type got);
         decoded_type want;
         if (expected_dates.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected response: %0d-%0d-%0d %0d:%0d:%0d epoch %0d",
                        got.stamp.full_year, got.stamp.month, got.stamp.day,
                        got.stamp.hour, got.stamp.minute, got.stamp.second, got.epoch);
            return;
         end
         want = expected_dates.pop_front();
         if (got.stamp.second !== want.stamp.second || got.stamp.minute !== want.stamp.minute ||
             got.stamp.hour !== want.stamp.hour || got.stamp.day !== want.stamp.day ||
             got.stamp.month !== want.stamp.month ||
             got.stamp.full_year !== want.stamp.full_year || got.epoch !== want.epoch) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display({"expected %0d-%0d-%0d %0d:%0d:%0d epoch %0d, ",
                         "got %0d-%0d-%0d %0d:%0d:%0d epoch %0d"},
                        want.stamp.full_year, want.stamp.month, want.stamp.day,
                        want.stamp.hour, want.stamp.minute, want.stamp.second, want.epoch,
                        got.stamp.full_year, got.stamp.month, got.stamp.day,
                        got.stamp.hour, got.stamp.minute, got.stamp.second, got.epoch);
         end
      endfunction

      function int unsigned pending();
         return expected_dates.size();
      endfunction
   endclass

   // clock, reset and dut pins; every input starts at a known value
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid       = 1'b0;
   logic              req_stall;
   logic [BYTE_W-1:0] req_raw_seconds = '0;
   logic [BYTE_W-1:0] req_raw_minutes = '0;
   logic [BYTE_W-1:0] req_raw_hours   = '0;
   logic [BYTE_W-1:0] req_raw_day     = '0;
   logic [BYTE_W-1:0] req_raw_month   = '0;
   logic [BYTE_W-1:0] req_raw_year    = '0;
   logic [BYTE_W-1:0] req_raw_century = '0;
   logic [BYTE_W-1:0] req_status_b    = '0;

   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [BYTE_W-1:0]  rsp_second;
   logic [BYTE_W-1:0]  rsp_minute;
   logic [BYTE_W-1:0]  rsp_hour;
   logic [BYTE_W-1:0]  rsp_day;
   logic [BYTE_W-1:0]  rsp_month;
   logic [YEAR_W-1:0]  rsp_full_year;
   logic [EPOCH_W-1:0] rsp_epoch_seconds;

   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_data  = 1'b0;

   // percent chance per cycle that the sender idles / the receiver stalls
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned cycle_count    = 0;

   epoch_scoreboard sb;

   rtc_date_to_epoch_seconds_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_raw_seconds   (req_raw_seconds),
      .req_raw_minutes   (req_raw_minutes),
      .req_raw_hours     (req_raw_hours),
      .req_raw_day       (req_raw_day),
      .req_raw_month     (req_raw_month),
      .req_raw_year      (req_raw_year),
      .req_raw_century   (req_raw_century),
      .req_status_b      (req_status_b),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_second        (rsp_second),
      .rsp_minute        (rsp_minute),
      .rsp_hour          (rsp_hour),
      .rsp_day           (rsp_day),
      .rsp_month         (rsp_month),
      .rsp_full_year     (rsp_full_year),
      .rsp_epoch_seconds (rsp_epoch_seconds),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   always #CLK_HALF clock = ~clock;

   // receiver back-pressure, changed on the falling edge only
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // response monitor: a transaction completes on a rising edge with valid high, stall low
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(decoded_type'({rsp_second, rsp_minute, rsp_hour, rsp_day, rsp_month,
                                        rsp_full_year, rsp_epoch_seconds}));
   end

   // watchdog against a hung handshake
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("rtc_date_to_epoch_seconds_unit: mismatch");
         $finish;
      end
   end

   // drive one snapshot: optional idle gap, then hold it until the dut takes it
   // entered and left at a falling edge
   task automatic push_snapshot(input snapshot_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_raw_seconds <= s.seconds;
      req_raw_minutes <= s.minutes;
      req_raw_hours   <= s.hours;
      req_raw_day     <= s.day;
      req_raw_month   <= s.month;
      req_raw_year    <= s.year;
      req_raw_century <= s.century;
      req_status_b    <= s.status_b;
      do @(posedge clock); while (req_stall);
      sb.note_snapshot(s);
      @(negedge clock);
   endtask

   // century-present flag write, only once the pipe has drained
   task automatic write_century_flag(input bit flag);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= flag;
      do @(posedge clock); while (!csr_ready);
      sb.century_en = flag;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [BYTE_W-1:0] to_bcd(input int unsigned v);
      return BYTE_W'(((v / 10) << 4) | (v % 10));
   endfunction

   // mostly plausible clock readings in either encoding; the rest raw noise
   function automatic snapshot_type random_snapshot();
      snapshot_type s;
      bit           binary, h24, pm;
      int unsigned  hr;
      if ($urandom_range(99) < 20) begin
         s = {$urandom, $urandom};
         return s;
      end
      binary = $urandom_range(1);
      h24    = $urandom_range(1);
      pm     = $urandom_range(1);
      hr     = h24 ? $urandom_range(23) : $urandom_range(12, 1);
      s.status_b = BYTE_W'($urandom);
      s.status_b[STB_BINARY] = binary;
      s.status_b[STB_24H]    = h24;
      if (binary) begin
         s.seconds = BYTE_W'($urandom_range(59));
         s.minutes = BYTE_W'($urandom_range(59));
         s.hours   = BYTE_W'(hr) | (h24 ? 8'h00 : {pm, 7'd0});
         s.day     = BYTE_W'($urandom_range(31, 1));
         s.month   = BYTE_W'($urandom_range(12, 1));
         s.year    = BYTE_W'($urandom_range(99));
         s.century = BYTE_W'($urandom_range(3) == 0 ? $urandom_range(99) : $urandom_range(21, 19));
      end else begin
         s.seconds = to_bcd($urandom_range(59));
         s.minutes = to_bcd($urandom_range(59));
         s.hours   = to_bcd(hr) | (h24 ? 8'h00 : {pm, 7'd0});
         s.day     = to_bcd($urandom_range(31, 1));
         s.month   = to_bcd($urandom_range(12, 1));
         s.year    = to_bcd($urandom_range(99));
         s.century = to_bcd($urandom_range(3) == 0 ? $urandom_range(99) : $urandom_range(21, 19));
      end
      return s;
   endfunction

   initial begin
      sb = new();

      // synchronous reset, released on a falling edge
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed corners, first with the century flag at its reset value of zero
      //                sec    min    hour   day    mon    year   cent   stat b
      push_snapshot('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}); // day 0, month 0
      push_snapshot('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}); // binary, all ones
      push_snapshot('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00}); // bad bcd digits, pm
      push_snapshot('{8'h59, 8'h59, 8'h23, 8'h29, 8'h02, 8'h24, 8'h00, 8'h02}); // leap day, 24h
      push_snapshot('{8'h00, 8'h00, 8'h92, 8'h01, 8'h03, 8'h24, 8'h00, 8'h00}); // 12 pm wraps to 0
      push_snapshot('{8'h30, 8'h15, 8'h91, 8'h31, 8'h12, 8'h99, 8'h00, 8'h00}); // 11 pm, december
      push_snapshot('{8'd5,  8'd6,  8'h85, 8'd7,  8'd8,  8'd9,  8'd0,  8'h04}); // binary 12h pm
      push_snapshot('{8'd5,  8'd6,  8'h85, 8'd7,  8'd8,  8'd9,  8'd0,  8'h06}); // binary 24h, bit 7
      push_snapshot('{8'h10, 8'h20, 8'h08, 8'h15, 8'h13, 8'h10, 8'h00, 8'h02}); // month 13
      push_snapshot('{8'd1,  8'd2,  8'd3,  8'd4,  8'd0,  8'd50, 8'd0,  8'h06}); // binary month 0
      push_snapshot('{8'd1,  8'd2,  8'd3,  8'd4,  8'd13, 8'd50, 8'd0,  8'h06}); // binary month 13
      push_snapshot('{8'h45, 8'h44, 8'h86, 8'h00, 8'h07, 8'h01, 8'h00, 8'hF9}); // pm, day 0, odd bits

      // the same path with a supplied century register
      write_century_flag(1'b1);
      push_snapshot('{8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h69, 8'h19, 8'h02}); // 1969, before epoch
      push_snapshot('{8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70, 8'h19, 8'h02}); // epoch origin
      push_snapshot('{8'h00, 8'h00, 8'h00, 8'h01, 8'h06, 8'h99, 8'h00, 8'h02}); // century zero
      push_snapshot('{8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h21, 8'h02}); // 2100 not leap
      push_snapshot('{8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h20, 8'h02}); // 2000 leap
      push_snapshot('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd12, 8'hFF, 8'hFF, 8'h06}); // largest year
      push_snapshot('{8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h12, 8'hFF, 8'hFF, 8'h00}); // bad bcd century
      push_snapshot('{8'h07, 8'h14, 8'h03, 8'h19, 8'h01, 8'h38, 8'h20, 8'h02}); // january 2038
      push_snapshot('{8'd0,  8'd0,  8'd0,  8'd0,  8'd2,  8'd99, 8'd19, 8'h06}); // binary, day 0

      // random phases: each idling style once per century setting
      for (int unsigned phase = 0; phase < 8; phase++) begin
         write_century_flag(phase[0]);
         case (phase / 2)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 67;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 67;
            end
            default: begin
               send_idle_pct  = 7;
               recv_stall_pct = 7;
            end
         endcase
         for (int unsigned n = 0; n < PHASE_ITEMS; n++)
            push_snapshot(random_snapshot());
      end
      req_valid <= 1'b0;

      // drain, then a short tail to catch stray responses
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("rtc_date_to_epoch_seconds_unit: match");
      else
         $display("rtc_date_to_epoch_seconds_unit: mismatch");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/rdte_pkg.sv
rtl/core/rtc_date_to_epoch_seconds_unit.sv
rtl/core/rdte_checker.sv
verif/rtc_date_to_epoch_seconds_unit_tb.sv
